@@ rtl/itc_pkg.sv @@
// Shared types, port codes and count helpers for the two-channel interval timer.
package itc_pkg;

    // Request action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Decoded I/O ports
    localparam logic [7:0] PORT_CH0  = 8'h40;
    localparam logic [7:0] PORT_CH2  = 8'h42;
    localparam logic [7:0] PORT_CMD  = 8'h43;
    localparam logic [7:0] PORT_GATE = 8'h61;

    // Command byte fields
    localparam logic [1:0] SEL_CH0     = 2'b00;
    localparam logic [1:0] SEL_CH2     = 2'b10;
    localparam logic [1:0] ACCESS_LOHI = 2'b11;
    localparam logic [1:0] MODE_SQUARE = 2'b11;

    // Bit positions on the gate port
    localparam int GATE_BIT = 0;
    localparam int OUT_BIT  = 5;

    localparam int COUNT_W = 17;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] port;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ch0_out;
        logic       ch0_rise;
        logic       ch2_out;
    } rsp_t;

    typedef enum logic [2:0] {
        CH_IDLE,
        CH_TICK,
        CH_CMD,
        CH_COUNT,
        CH_GATE
    } chan_op_t;

    typedef struct packed {
        chan_op_t   op;
        logic [7:0] data;
        logic       gate;      // gate level seen by the channel after this request
        logic       gate_was;  // gate level before a gate port write
    } chan_ctl_t;

    typedef struct packed {
        logic level;
        logic level_next;
    } chan_stat_t;

    // A reload of zero counts 65536 ticks.
    function automatic logic [COUNT_W-1:0] full_count(input logic [15:0] reload);
        full_count = (reload == 16'd0) ? {1'b1, 16'd0} : {1'b0, reload};
    endfunction

    // High half lasts (N+1)/2 ticks, low half N/2 ticks.
    function automatic logic [COUNT_W-1:0] half_len(input logic [COUNT_W-1:0] full,
                                                    input logic level);
        logic [COUNT_W:0] sum;
        sum = {1'b0, full} + {{COUNT_W{1'b0}}, 1'b1};
        if (level)
            half_len = sum[COUNT_W:1];
        else
            half_len = full >> 1;
    endfunction

endpackage

@@ rtl/itc_channel.sv @@
// One timer channel: count registers, mode 0 and mode 3 sequencing.
module itc_channel (
    input  logic              clk,
    input  logic              rst_n,
    input  itc_pkg::chan_ctl_t ctl,
    output itc_pkg::chan_stat_t stat
);
    import itc_pkg::*;

    logic [15:0]        reload_reg, reload_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [2:0]         mode_reg, mode_next;
    logic               level_reg, level_next;
    logic               expect_hi_reg, expect_hi_next;
    logic               armed_reg, armed_next;

    logic               square;
    logic [COUNT_W-1:0] full_cur;
    logic [COUNT_W-1:0] full_new;
    logic [COUNT_W-1:0] count_dec;
    logic [15:0]        reload_hi;
    logic               flip;

    assign square    = (mode_reg[1:0] == MODE_SQUARE);
    assign full_cur  = full_count(reload_reg);
    assign reload_hi = {ctl.data, reload_reg[7:0]};
    assign full_new  = full_count(reload_hi);
    assign count_dec = (count_reg != '0) ? count_reg - COUNT_W'(1) : count_reg;
    assign flip      = ~level_reg;

    always_comb
    begin
        reload_next    = reload_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        level_next     = level_reg;
        expect_hi_next = expect_hi_reg;
        armed_next     = armed_reg;
        unique case (ctl.op)
            CH_TICK:
            begin
                if (armed_reg)
                begin
                    if (!square)
                    begin
                        if (ctl.gate)
                        begin
                            count_next = count_dec;
                            if (count_dec == '0)
                            begin
                                level_next = 1'b1;
                                armed_next = 1'b0;
                            end
                        end
                    end
                    else if (!ctl.gate)
                    begin
                        level_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_dec;
                        if (count_dec == '0)
                        begin
                            // empty low half on a count of one: stay high
                            if (!flip && full_cur == COUNT_W'(1))
                            begin
                                level_next = level_reg;
                                count_next = half_len(full_cur, level_reg);
                            end
                            else
                            begin
                                level_next = flip;
                                count_next = half_len(full_cur, flip);
                            end
                        end
                    end
                end
            end
            CH_CMD:
            begin
                mode_next      = ctl.data[3:1];
                armed_next     = 1'b0;
                expect_hi_next = 1'b0;
                level_next     = (ctl.data[2:1] == MODE_SQUARE);
            end
            CH_COUNT:
            begin
                if (!expect_hi_reg)
                begin
                    reload_next    = {reload_reg[15:8], ctl.data};
                    expect_hi_next = 1'b1;
                    armed_next     = 1'b0;
                end
                else
                begin
                    reload_next    = reload_hi;
                    expect_hi_next = 1'b0;
                    armed_next     = 1'b1;
                    if (square)
                    begin
                        level_next = 1'b1;
                        count_next = half_len(full_new, 1'b1);
                    end
                    else
                    begin
                        level_next = 1'b0;
                        count_next = full_new;
                    end
                end
            end
            CH_GATE:
            begin
                if (square)
                begin
                    if (!ctl.gate)
                    begin
                        level_next = 1'b1;
                    end
                    else if (!ctl.gate_was && armed_reg)
                    begin
                        // restart at the top of the high half
                        level_next = 1'b1;
                        count_next = half_len(full_cur, 1'b1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= '0;
            count_reg     <= '0;
            mode_reg      <= '0;
            level_reg     <= 1'b0;
            expect_hi_reg <= 1'b0;
            armed_reg     <= 1'b0;
        end
        else
        begin
            reload_reg    <= reload_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            expect_hi_reg <= expect_hi_next;
            armed_reg     <= armed_next;
        end
    end

    assign stat.level      = level_reg;
    assign stat.level_next = level_next;

endmodule

@@ rtl/interval_timer_two_channel_top.sv @@
// Top level of the two-channel interval timer: request stage, decode, result register.
// Usage:
//   Each request on req (valid/ready) is one of: an input clock tick, a byte
//   write to an I/O port, or a byte read from an I/O port. Port 0x43 takes
//   command bytes, 0x40 and 0x42 take the low-then-high count bytes of
//   channels 0 and 2, and 0x61 holds the channel 2 gate in bit 0 and shows
//   channel 2's output in bit 5 on reads.
//   Every request produces exactly one result on rsp (valid/ready): the read
//   byte (zero unless a read of 0x61), both output levels after the request,
//   and ch0_rise, the channel 0 interrupt edge on a tick.
// Flow and throughput:
//   A request sits in the request register, passes both channels in one pass
//   of logic and loads the result register once that register is free or
//   drains. One request per cycle is sustained while rsp_ready stays high;
//   the single-pass channel update sets that figure.
// Reset:
//   rst_n (asynchronous, active low) clears all counts, modes, levels and the
//   gate byte, and empties both registers.
// Stall:
//   While rsp is held, the request register still takes one more request;
//   after that req_ready drops until the result is taken.
module interval_timer_two_channel_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  itc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output itc_pkg::rsp_t rsp
);
    import itc_pkg::*;

    logic       stage_valid_reg, stage_valid_next;
    req_t       stage_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;
    logic [7:0] gate_reg, gate_next;

    logic       advance;
    logic       accept;
    logic       step;
    logic       cmd_ok;

    chan_ctl_t  ctl0, ctl2;
    chan_stat_t stat0, stat2;

    // Move the held request on whenever the result register is free or drains.
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !stage_valid_reg || advance;
    assign accept    = req_valid && req_ready;
    assign step      = stage_valid_reg && advance;

    // Drop commands with a latch, readback or single-byte access form.
    assign cmd_ok   = (stage_reg.write_data[5:4] == ACCESS_LOHI);

    // Steer the request to the channels.
    always_comb
    begin
        gate_next     = gate_reg;
        ctl0.op       = CH_IDLE;
        ctl0.data     = stage_reg.write_data;
        ctl0.gate     = 1'b1;
        ctl0.gate_was = 1'b1;
        ctl2.op       = CH_IDLE;
        ctl2.data     = stage_reg.write_data;
        ctl2.gate_was = gate_reg[GATE_BIT];
        if (step)
        begin
            unique case (stage_reg.action)
                ACT_TICK:
                begin
                    ctl0.op = CH_TICK;
                    ctl2.op = CH_TICK;
                end
                ACT_WRITE:
                begin
                    unique case (stage_reg.port)
                        PORT_CMD:
                        begin
                            if (cmd_ok && stage_reg.write_data[7:6] == SEL_CH0)
                                ctl0.op = CH_CMD;
                            else if (cmd_ok && stage_reg.write_data[7:6] == SEL_CH2)
                                ctl2.op = CH_CMD;
                        end
                        PORT_CH0:  ctl0.op = CH_COUNT;
                        PORT_CH2:  ctl2.op = CH_COUNT;
                        PORT_GATE:
                        begin
                            ctl2.op   = CH_GATE;
                            gate_next = stage_reg.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        ctl2.gate = gate_next[GATE_BIT];
    end

    itc_channel u_ch0 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl0),
        .stat  (stat0)
    );

    itc_channel u_ch2 (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl2),
        .stat  (stat2)
    );

    // Form the result from the levels after this request.
    always_comb
    begin
        rsp_next.read_data = '0;
        if (stage_reg.action == ACT_READ && stage_reg.port == PORT_GATE)
        begin
            rsp_next.read_data          = gate_reg;
            rsp_next.read_data[OUT_BIT] = stat2.level;
        end
        rsp_next.ch0_out  = stat0.level_next;
        rsp_next.ch0_rise = (stage_reg.action == ACT_TICK) && !stat0.level &&
                            stat0.level_next;
        rsp_next.ch2_out  = stat2.level_next;
    end

    assign stage_valid_next = accept || (stage_valid_reg && !advance);
    assign rsp_valid_next   = step || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            gate_reg        <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            gate_reg        <= gate_next;
        end
    end

    // Hold payloads until the next transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= req;
        if (step)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
